// ===== sv/frustum_point_culling_defines.svh =====
// Assertion macros shared by the frustum point culling RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef FRUSTUM_POINT_CULLING_DEFINES_SVH
`define FRUSTUM_POINT_CULLING_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define FPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fpc: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define FPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fpc: next-cycle check failed");

`endif

// ===== sv/fpc_pkg.sv =====
// Types and constants for the frustum point culling block.
// No dependencies; used by fpc_cell, fpc_plane and the top level.
package fpc_pkg;

  localparam int unsigned ElemW  = 32;
  localparam int unsigned Rows   = 4;
  localparam int unsigned Planes = 6;
  // four 64-bit products summed, then plane = row3 +/- rowk
  localparam int unsigned AccW   = 66;
  localparam int unsigned DistW  = 67;

  // column that holds the w entries (no part in the plane normal)
  localparam logic [1:0] WCol = 2'd3;

  // plane order: left, right, top, bottom, near, far
  localparam logic [1:0] PlaneRow [Planes] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
  // bit i set: plane i is row3 minus its row
  localparam logic [Planes-1:0] PlaneNeg = 6'b100110;

  typedef enum logic {
    ReqLoad = 1'b0,
    ReqTest = 1'b1
  } req_e;

  // one item as it travels along the chain of column cells
  typedef struct packed {
    logic                         valid;
    req_e                         req;
    logic [3:0]                   idx;
    logic signed [ElemW-1:0]      value;
    logic signed [ElemW-1:0]      x;
    logic signed [ElemW-1:0]      y;
    logic signed [ElemW-1:0]      z;
    logic [Rows-1:0][AccW-1:0]    acc;  // partial row dot products
    logic [Planes-1:0]            nz;   // plane normal seen non-zero
  } stage_t;

endpackage

// ===== sv/fpc_cell.sv =====
// One column cell: holds matrix column col_i and adds its share of each row dot product.
// Depends on fpc_pkg.
module fpc_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic [1:0]                         col_i,
  input  logic signed [fpc_pkg::ElemW-1:0]   coord_i,
  input  fpc_pkg::stage_t                    stage_i,
  output fpc_pkg::stage_t                    stage_o
);

  logic signed [fpc_pkg::ElemW-1:0]   col_q [fpc_pkg::Rows];
  logic signed [fpc_pkg::ElemW-1:0]   col_d [fpc_pkg::Rows];
  logic signed [2*fpc_pkg::ElemW-1:0] prod  [fpc_pkg::Rows];
  logic [fpc_pkg::Rows-1:0][fpc_pkg::AccW-1:0] acc_nx;
  logic signed [fpc_pkg::ElemW:0]     nsum  [fpc_pkg::Planes];
  logic [fpc_pkg::Planes-1:0]         nz_loc;
  fpc_pkg::stage_t                    stage_d, stage_q;
  logic                               valid_q;

  // element write when a load for this column moves on
  always_comb begin
    for (int k = 0; k < fpc_pkg::Rows; k++) col_d[k] = col_q[k];
    if (en_i && stage_i.valid && (stage_i.req == fpc_pkg::ReqLoad) &&
        (stage_i.idx[3:2] == col_i)) begin
      col_d[stage_i.idx[1:0]] = stage_i.value;
    end
  end

  // column times coordinate, added to the incoming partial sums
  always_comb begin
    for (int k = 0; k < fpc_pkg::Rows; k++) begin
      prod[k]   = col_q[k] * coord_i;
      acc_nx[k] = $signed(stage_i.acc[k]) + fpc_pkg::AccW'(prod[k]);
    end
  end

  // normal component of each plane from this column
  always_comb begin
    for (int i = 0; i < fpc_pkg::Planes; i++) begin
      if (fpc_pkg::PlaneNeg[i]) begin
        nsum[i] = (fpc_pkg::ElemW+1)'(col_q[fpc_pkg::WCol])
                - (fpc_pkg::ElemW+1)'(col_q[fpc_pkg::PlaneRow[i]]);
      end else begin
        nsum[i] = (fpc_pkg::ElemW+1)'(col_q[fpc_pkg::WCol])
                + (fpc_pkg::ElemW+1)'(col_q[fpc_pkg::PlaneRow[i]]);
      end
      nz_loc[i] = (nsum[i] != '0) && (col_i != fpc_pkg::WCol);
    end
  end

  always_comb begin
    stage_d = stage_i;
    if (stage_i.req == fpc_pkg::ReqTest) begin
      stage_d.acc = acc_nx;
      stage_d.nz  = stage_i.nz | nz_loc;
    end
  end

  // matrix column, cleared to zero on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < fpc_pkg::Rows; k++) col_q[k] <= '0;
    end else begin
      for (int k = 0; k < fpc_pkg::Rows; k++) col_q[k] <= col_d[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_i.valid;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  always_comb begin
    stage_o       = stage_q;
    stage_o.valid = valid_q;
  end

endmodule

// ===== sv/fpc_plane.sv =====
// Plane stage: forms the six plane distances from the row dots and registers the verdict.
// Depends on fpc_pkg; this register is the block's output register.
module fpc_plane (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fpc_pkg::stage_t stage_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            inside_o
);

  logic signed [fpc_pkg::DistW-1:0] d_w;
  logic signed [fpc_pkg::DistW-1:0] d_r     [fpc_pkg::Planes];
  logic signed [fpc_pkg::DistW-1:0] pl_dist [fpc_pkg::Planes];
  logic [fpc_pkg::Planes-1:0]       cull;
  logic                             take;
  logic                             valid_q, inside_q;

  assign in_ready_o = !valid_q || out_ready_i;
  assign take       = in_ready_o && stage_i.valid && (stage_i.req == fpc_pkg::ReqTest);

  // distance = row3 +/- row r; a plane with zero normal never culls
  always_comb begin
    d_w = fpc_pkg::DistW'($signed(stage_i.acc[fpc_pkg::WCol]));
    for (int i = 0; i < fpc_pkg::Planes; i++) begin
      d_r[i] = fpc_pkg::DistW'($signed(stage_i.acc[fpc_pkg::PlaneRow[i]]));
      pl_dist[i] = fpc_pkg::PlaneNeg[i] ? (d_w - d_r[i]) : (d_w + d_r[i]);
      cull[i] = stage_i.nz[i] && pl_dist[i][fpc_pkg::DistW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      inside_q <= ~|cull;
    end
  end

  assign out_valid_o = valid_q;
  assign inside_o    = inside_q;

endmodule

// ===== sv/frustum_point_culling.sv =====
// Frustum point culling top level: four column cells in a chain and the plane stage.
// Depends on fpc_pkg, fpc_cell, fpc_plane and frustum_point_culling_defines.svh.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+------------------------------------
//   in       | input     | in_valid_i / in_ready_o | req_type_i, elem_index_i,
//            |           |                         | elem_value_i, point_x/y/z_i
//   out      | output    | out_valid_o/out_ready_i | inside_res_o
//
// One item per cycle unless the output stalls; a test item is loaded into the first column
// cell at its accepting edge, then passes three more cells and the plane register, which holds its result.
// Loads travel the same chain and write their element as they pass their column's
// cell, so they give no result.
// Reset clears the matrix to zero and empties the chain at once.
// A stall backs up only as far as the first empty stage.
`include "frustum_point_culling_defines.svh"

module frustum_point_culling #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [3:0]  elem_index_i,
  input  logic signed [31:0] elem_value_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        inside_res_o
);

  localparam logic signed [fpc_pkg::ElemW-1:0] OneFix =
    fpc_pkg::ElemW'(64'sd1 << FRAC_BITS);

  fpc_pkg::stage_t                  st    [fpc_pkg::Rows+1];
  logic                             en    [fpc_pkg::Rows+1];
  logic                             plane_ready;
  logic signed [fpc_pkg::ElemW-1:0] coord [fpc_pkg::Rows];

  // incoming item as the head of the chain
  always_comb begin
    st[0]       = '0;
    st[0].valid = in_valid_i;
    st[0].req   = fpc_pkg::req_e'(req_type_i);
    st[0].idx   = elem_index_i;
    st[0].value = elem_value_i;
    st[0].x     = point_x_i;
    st[0].y     = point_y_i;
    st[0].z     = point_z_i;
  end

  // each cell multiplies by its own coordinate; the w column by one
  always_comb begin
    coord[0] = st[0].x;
    coord[1] = st[1].y;
    coord[2] = st[2].z;
    coord[3] = OneFix;
  end

  // a stage moves when its slot is empty or its successor moves
  always_comb begin
    en[fpc_pkg::Rows] = plane_ready;
    for (int c = fpc_pkg::Rows - 1; c >= 0; c--) begin
      en[c] = !st[c+1].valid || en[c+1];
    end
  end

  assign in_ready_o = en[0];

  for (genvar c = 0; c < fpc_pkg::Rows; c++) begin : g_cell
    fpc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[c]),
      .col_i   (2'(c)),
      .coord_i (coord[c]),
      .stage_i (st[c]),
      .stage_o (st[c+1])
    );
  end

  fpc_plane u_plane (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (st[fpc_pkg::Rows]),
    .in_ready_o  (plane_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .inside_o    (inside_res_o)
  );

  // input held off only when every stage is full and the output stalls
  `FPC_ASSERT_IMP(a_ready_full, !in_ready_o, st[1].valid && st[2].valid && st[3].valid && st[4].valid && out_valid_o && !out_ready_i)
  // a point with no non-zero plane normal is always inside
  `FPC_ASSERT_NXT(a_zero_normal, st[4].valid && (st[4].req == fpc_pkg::ReqTest) && (st[4].nz == '0) && en[4], out_valid_o && inside_res_o)
  // results come only from test items leaving the chain
  `FPC_ASSERT_IMP(a_result_src, $rose(out_valid_o), $past(st[4].valid && (st[4].req == fpc_pkg::ReqTest)))

endmodule
